// ===== sv/vtyp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtyp_pkg
// Shared types, constants and the arctangent table for the yaw/pitch
// converter.
// ----------------------------------------------------------------------------
package vtyp_pkg;

    localparam int COORD_W    = 16;
    localparam int GUARD_BITS = 24;
    localparam int DATA_W     = COORD_W + GUARD_BITS + 3;
    localparam int ANG_W      = 32;
    localparam int ANG_FRAC   = 20;
    localparam int OUT_SHIFT  = 13;
    localparam int MAX_STEPS  = 24;
    localparam int GAIN_FRAC  = 30;
    localparam int HI_W       = DATA_W - 1 - GAIN_FRAC;
    localparam int OUT_W      = 16;

    localparam logic [GAIN_FRAC-1:0] INV_GAIN   = GAIN_FRAC'(652032875);
    localparam logic [OUT_W-1:0]     FULL_TURN  = OUT_W'(46080);
    localparam logic [OUT_W-1:0]     PITCH_UP   = OUT_W'(34560);
    localparam logic [OUT_W-1:0]     PITCH_DOWN = OUT_W'(11520);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    localparam ang_t HALF_TURN_FINE = ang_t'(180) <<< ANG_FRAC;
    localparam ang_t ROUND_BIAS     = ang_t'(1) <<< (OUT_SHIFT - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0] yaw_angle;
        logic [OUT_W-1:0] pitch_angle;
    } out_beat_t;

    typedef struct packed {
        data_t x;
        data_t y;
        ang_t  ang;
    } cvec_t;

    typedef struct packed {
        logic             xy_zero;
        logic             z_pos;
        logic [OUT_W-1:0] yaw;
        data_t            z_fine;
    } side_t;

    // round(atan(2^-i) * 2^20), degrees
    function automatic ang_t atan_entry(input int unsigned idx);
        ang_t v;
        unique case (idx)
            0:       v = ang_t'(47185920);
            1:       v = ang_t'(27855475);
            2:       v = ang_t'(14718068);
            3:       v = ang_t'(7471121);
            4:       v = ang_t'(3750058);
            5:       v = ang_t'(1876857);
            6:       v = ang_t'(938658);
            7:       v = ang_t'(469357);
            8:       v = ang_t'(234682);
            9:       v = ang_t'(117342);
            10:      v = ang_t'(58671);
            11:      v = ang_t'(29335);
            12:      v = ang_t'(14668);
            13:      v = ang_t'(7334);
            14:      v = ang_t'(3667);
            15:      v = ang_t'(1833);
            16:      v = ang_t'(917);
            17:      v = ang_t'(458);
            18:      v = ang_t'(229);
            19:      v = ang_t'(115);
            20:      v = ang_t'(57);
            21:      v = ang_t'(29);
            22:      v = ang_t'(14);
            23:      v = ang_t'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/vtyp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// vtyp_cordic_stage
// One registered CORDIC vectoring micro-rotation, drives y toward zero.
// ----------------------------------------------------------------------------
module vtyp_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            load,
    input  vtyp_pkg::cvec_t vec_in,
    input  vtyp_pkg::side_t side_in,
    output vtyp_pkg::cvec_t vec_out,
    output vtyp_pkg::side_t side_out
);

    localparam vtyp_pkg::ang_t ATAN = vtyp_pkg::atan_entry(STEP);

    vtyp_pkg::data_t xs;
    vtyp_pkg::data_t ys;
    vtyp_pkg::cvec_t vec_next;
    vtyp_pkg::cvec_t vec_reg;
    vtyp_pkg::side_t side_reg;

    always_comb begin
        xs = vec_in.x >>> STEP;
        ys = vec_in.y >>> STEP;
        if (!vec_in.y[vtyp_pkg::DATA_W-1]) begin
            vec_next.x   = vec_in.x + ys;
            vec_next.y   = vec_in.y - xs;
            vec_next.ang = vec_in.ang + ATAN;
        end else begin
            vec_next.x   = vec_in.x - ys;
            vec_next.y   = vec_in.y + xs;
            vec_next.ang = vec_in.ang - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vec_reg  <= vec_next;
            side_reg <= side_in;
        end
    end

    assign vec_out  = vec_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/vtyp_horiz.sv =====
// ----------------------------------------------------------------------------
// vtyp_horiz
// Gain correction of the horizontal length (two stages) and heading rounding.
// ----------------------------------------------------------------------------
module vtyp_horiz (
    input  logic            aclk,
    input  logic            load_a,
    input  logic            load_b,
    input  vtyp_pkg::cvec_t vec_in,
    input  vtyp_pkg::side_t side_in,
    output vtyp_pkg::data_t len_out,
    output vtyp_pkg::side_t side_out
);

    localparam int HP_W = vtyp_pkg::HI_W + vtyp_pkg::GAIN_FRAC;
    localparam int LP_W = 2 * vtyp_pkg::GAIN_FRAC;

    logic [vtyp_pkg::HI_W-1:0]      hi;
    logic [vtyp_pkg::GAIN_FRAC-1:0] lo;
    logic [LP_W-1:0]                lo_prod;
    logic [HP_W-1:0]                hi_prod_next;
    logic [HP_W-1:0]                hi_prod_reg;
    logic [vtyp_pkg::GAIN_FRAC-1:0] lo_top_next;
    logic [vtyp_pkg::GAIN_FRAC-1:0] lo_top_reg;
    vtyp_pkg::ang_t                 q;
    vtyp_pkg::ang_t                 q_wrap;
    vtyp_pkg::side_t                side_next;
    vtyp_pkg::side_t                side_a_reg;
    vtyp_pkg::side_t                side_b_reg;
    vtyp_pkg::data_t                len_next;
    vtyp_pkg::data_t                len_reg;

    always_comb begin
        hi           = vec_in.x[vtyp_pkg::DATA_W-2:vtyp_pkg::GAIN_FRAC];
        lo           = vec_in.x[vtyp_pkg::GAIN_FRAC-1:0];
        hi_prod_next = HP_W'(hi) * HP_W'(vtyp_pkg::INV_GAIN);
        lo_prod      = LP_W'(lo) * LP_W'(vtyp_pkg::INV_GAIN);
        lo_top_next  = lo_prod[LP_W-1:vtyp_pkg::GAIN_FRAC];

        q      = (vec_in.ang + vtyp_pkg::ROUND_BIAS) >>> vtyp_pkg::OUT_SHIFT;
        q_wrap = q[vtyp_pkg::ANG_W-1] ? q + vtyp_pkg::ang_t'(vtyp_pkg::FULL_TURN) : q;
        side_next     = side_in;
        side_next.yaw = q_wrap[vtyp_pkg::OUT_W-1:0];

        len_next = vtyp_pkg::data_t'(hi_prod_reg) + vtyp_pkg::data_t'(lo_top_reg);
    end

    always_ff @(posedge aclk) begin
        if (load_a) begin
            hi_prod_reg <= hi_prod_next;
            lo_top_reg  <= lo_top_next;
            side_a_reg  <= side_next;
        end
        if (load_b) begin
            len_reg    <= len_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign len_out  = len_reg;
    assign side_out = side_b_reg;

endmodule

// ===== sv/vector_to_yaw_pitch.sv =====
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch
// Signed 3D vector to yaw and pitch in 1/128 degree, two CORDIC passes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries x_coord, y_coord, z_coord (16-bit signed).
//   m_ channel: one beat carries yaw_angle (0..46079) and pitch_angle
//   (1..46080, 360 deg minus elevation), both in 1/128 degree.
//   Exactly one result beat per input beat, in order.
//   Throughput: one beat per cycle while m_ready is high, set by the fully
//   unrolled micro-rotation stages of the heading and elevation passes
//   plus two stages for the gain multiply.
//   Each stage carries its own valid bit and loads when it is empty or its
//   content moves on, so bubbles are squeezed out while m_ready is low;
//   s_ready drops only once every stage holds a beat and m_ready is low.
//   Reset (aresetn low, synchronous) empties the pipe; no beat is lost or
//   repeated under any stall pattern.
//   A vector with x and y both zero gives yaw 0 and pitch 270 deg when
//   z > 0, otherwise 90 deg.
// ----------------------------------------------------------------------------
module vector_to_yaw_pitch #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vtyp_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vtyp_pkg::out_beat_t m_data
);

    localparam int N      = (CORDIC_STEPS < vtyp_pkg::MAX_STEPS) ?
                            CORDIC_STEPS : vtyp_pkg::MAX_STEPS;
    localparam int STAGES = 2 * N + 4;
    localparam int CNT_W  = $clog2(STAGES + 1);
    localparam int ST_HA  = N + 1;
    localparam int ST_HB  = N + 2;
    localparam int ST_P2  = N + 3;
    localparam int ST_OUT = 2 * N + 3;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;

    vtyp_pkg::cvec_t p1_vec  [N+1];
    vtyp_pkg::side_t p1_side [N+1];
    vtyp_pkg::cvec_t p2_vec  [N+1];
    vtyp_pkg::side_t p2_side [N+1];

    vtyp_pkg::cvec_t     prep_vec_next;
    vtyp_pkg::cvec_t     prep_vec_reg;
    vtyp_pkg::side_t     prep_side_next;
    vtyp_pkg::side_t     prep_side_reg;
    vtyp_pkg::data_t     x_fine;
    vtyp_pkg::data_t     y_fine;
    vtyp_pkg::data_t     len;
    vtyp_pkg::side_t     h_side;
    vtyp_pkg::ang_t      e_q;
    vtyp_pkg::ang_t      pit;
    vtyp_pkg::out_beat_t out_next;
    vtyp_pkg::out_beat_t out_reg;

    // ready chain: a stage loads when empty or when its beat moves on
    assign rdy[STAGES] = m_ready;
    for (genvar k = 0; k < STAGES; k++) begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // input conditioning
    always_comb begin
        x_fine = vtyp_pkg::data_t'(s_data.x_coord) <<< vtyp_pkg::GUARD_BITS;
        y_fine = vtyp_pkg::data_t'(s_data.y_coord) <<< vtyp_pkg::GUARD_BITS;
        if (s_data.x_coord[vtyp_pkg::COORD_W-1]) begin
            prep_vec_next.x   = -x_fine;
            prep_vec_next.y   = -y_fine;
            prep_vec_next.ang = vtyp_pkg::HALF_TURN_FINE;
        end else begin
            prep_vec_next.x   = x_fine;
            prep_vec_next.y   = y_fine;
            prep_vec_next.ang = '0;
        end
        prep_side_next.xy_zero = (s_data.x_coord == '0) && (s_data.y_coord == '0);
        prep_side_next.z_pos   = !s_data.z_coord[vtyp_pkg::COORD_W-1] &&
                                 (s_data.z_coord != '0);
        prep_side_next.yaw     = '0;
        prep_side_next.z_fine  = vtyp_pkg::data_t'(s_data.z_coord) <<< vtyp_pkg::GUARD_BITS;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            prep_vec_reg  <= prep_vec_next;
            prep_side_reg <= prep_side_next;
        end
    end

    assign p1_vec[0]  = prep_vec_reg;
    assign p1_side[0] = prep_side_reg;

    // heading pass
    for (genvar i = 0; i < N; i++) begin : g_pass1
        vtyp_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .aclk     (aclk),
            .load     (rdy[i+1]),
            .vec_in   (p1_vec[i]),
            .side_in  (p1_side[i]),
            .vec_out  (p1_vec[i+1]),
            .side_out (p1_side[i+1])
        );
    end

    vtyp_horiz u_horiz (
        .aclk     (aclk),
        .load_a   (rdy[ST_HA]),
        .load_b   (rdy[ST_HB]),
        .vec_in   (p1_vec[N]),
        .side_in  (p1_side[N]),
        .len_out  (len),
        .side_out (h_side)
    );

    always_comb begin
        p2_vec[0].x   = len;
        p2_vec[0].y   = h_side.z_fine;
        p2_vec[0].ang = '0;
    end
    assign p2_side[0] = h_side;

    // elevation pass
    for (genvar i = 0; i < N; i++) begin : g_pass2
        vtyp_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .aclk     (aclk),
            .load     (rdy[ST_P2+i]),
            .vec_in   (p2_vec[i]),
            .side_in  (p2_side[i]),
            .vec_out  (p2_vec[i+1]),
            .side_out (p2_side[i+1])
        );
    end

    // output formatting
    always_comb begin
        e_q = (p2_vec[N].ang + vtyp_pkg::ROUND_BIAS) >>> vtyp_pkg::OUT_SHIFT;
        if (e_q[vtyp_pkg::ANG_W-1]) begin
            pit = -e_q;
        end else begin
            pit = vtyp_pkg::ang_t'(vtyp_pkg::FULL_TURN) - e_q;
        end
        if (p2_side[N].xy_zero) begin
            out_next.yaw_angle   = '0;
            out_next.pitch_angle = p2_side[N].z_pos ? vtyp_pkg::PITCH_UP :
                                                      vtyp_pkg::PITCH_DOWN;
        end else begin
            out_next.yaw_angle   = p2_side[N].yaw;
            out_next.pitch_angle = pit[vtyp_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[ST_OUT];
    assign m_data  = out_reg;

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.yaw_angle < vtyp_pkg::FULL_TURN))
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pitch_angle != '0) &&
                    (m_data.pitch_angle <= vtyp_pkg::FULL_TURN))
        else $error("pitch out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (valid_reg == '1)))
        else $error("input stalled with a bubble in the pipe");

    a_count_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && m_ready)) |=>
        (CNT_W'($countones(valid_reg)) ==
         CNT_W'($countones($past(valid_reg)) + 1)))
        else $error("beat lost or duplicated on entry");

    a_count_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_valid && s_ready) && m_valid && m_ready) |=>
        (CNT_W'($countones(valid_reg)) ==
         CNT_W'($countones($past(valid_reg)) - 1)))
        else $error("beat lost or duplicated on exit");

endmodule

// ===== test/tb_vector_to_yaw_pitch.sv =====
// ----------------------------------------------------------------------------
// tb_vector_to_yaw_pitch
// Self-checking bench for the vector to yaw/pitch converter. A queue of
// directed corner vectors and random vectors feeds a valid/ready driver;
// every accepted beat is run through a bit-exact two-pass CORDIC predictor
// and the monitor compares each result beat, in order, against it. Both
// sides idle in random bursts, and the receiver holds off once for long
// enough to fill the pipe and stall the input.
// ----------------------------------------------------------------------------
module tb_vector_to_yaw_pitch;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS         = 16;
    localparam int     ATAN_LEN      = 24;
    localparam int     RANDOM_VECS   = 1130;
    localparam int     QUIET_TAIL    = 120;
    localparam int     HOLD_AT       = 300;
    localparam int     HOLD_CYCLES   = 160;
    localparam int     DRAIN_CYCLES  = 2 * STEPS + 4 + 24;
    localparam int     WATCHDOG      = 2000;
    localparam longint GUARD_SCALE   = 64'sd1 << 24;
    localparam longint HALF_TURN     = 64'sd180 << 20;
    localparam longint TURN_OUT      = 64'sd46080;
    localparam longint LEVEL_UP      = 64'sd34560;
    localparam longint LEVEL_DOWN    = 64'sd11520;
    localparam bit [63:0] RECIP_GAIN = 64'd652032875;

    // round(atan(2^-i) * 2^20), degrees
    localparam longint ATAN_FINE [ATAN_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    localparam logic signed [15:0] CORNER_VALS [5] = '{-32768, -1, 0, 1, 32767};

    localparam logic signed [15:0] DIRECTED [23][3] = '{
        '{0, 0, 0},
        '{0, 0, 1},
        '{0, 0, -1},
        '{0, 0, 32767},
        '{0, 0, -32768},
        '{32767, 0, 0},
        '{-32768, 0, 0},
        '{-1, 0, 0},
        '{0, 1, 0},
        '{0, -1, 0},
        '{0, -32768, 5},
        '{1, -1, 0},
        '{32767, -1, 0},
        '{-32768, -1, 0},
        '{-32768, 1, 0},
        '{32767, 32767, 32767},
        '{-32768, -32768, -32768},
        '{-32768, 32767, -32768},
        '{32767, -32768, 32767},
        '{1, 0, -1},
        '{1, 0, 1},
        '{0, 1, -32768},
        '{-1, -1, 32767}
    };

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    vtyp_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vtyp_pkg::out_beat_t m_data;

    vtyp_pkg::in_beat_t  vec_queue[$];
    vtyp_pkg::out_beat_t angle_queue[$];

    int  total_vecs   = 0;
    int  in_count     = 0;
    int  out_count    = 0;
    int  err_count    = 0;
    int  idle_cycles  = 0;
    int  backpressure = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  in_taken     = 1'b0;
    bit  quiet        = 1'b0;

    vector_to_yaw_pitch #(.CORDIC_STEPS(STEPS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // vectoring pass: drives py toward zero, accumulates angle in 2^-20 deg
    function automatic void cordic_vectoring(inout longint px, inout longint py,
                                             inout longint ang);
        longint xs;
        longint ys;
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            xs = px >>> i;
            ys = py >>> i;
            if (py >= 0) begin
                px  = px + ys;
                py  = py - xs;
                ang = ang + ATAN_FINE[i];
            end else begin
                px  = px - ys;
                py  = py + xs;
                ang = ang - ATAN_FINE[i];
            end
        end
    endfunction

    function automatic longint fine_to_out(longint a);
        return (a + 64'sd4096) >>> 13;
    endfunction

    function automatic vtyp_pkg::out_beat_t predict_angles(vtyp_pkg::in_beat_t v);
        longint              xv, yv, zv;
        longint              x, y, ang, len, zz, elev, yaw, pitch;
        bit [63:0]           xu;
        vtyp_pkg::out_beat_t r;
        xv = longint'($signed(v.x_coord));
        yv = longint'($signed(v.y_coord));
        zv = longint'($signed(v.z_coord));
        if (xv == 0 && yv == 0) begin
            yaw   = 0;
            pitch = (zv > 0) ? LEVEL_UP : LEVEL_DOWN;
        end else begin
            x   = xv * GUARD_SCALE;
            y   = yv * GUARD_SCALE;
            ang = 0;
            if (x < 0) begin
                x   = -x;
                y   = -y;
                ang = HALF_TURN;
            end
            cordic_vectoring(x, y, ang);
            yaw = fine_to_out(ang) % TURN_OUT;
            if (yaw < 0)
                yaw = yaw + TURN_OUT;

            xu   = x;
            len  = longint'((xu >> 30) * RECIP_GAIN
                            + (((xu & 64'h3FFF_FFFF) * RECIP_GAIN) >> 30));
            zz   = zv * GUARD_SCALE;
            elev = 0;
            cordic_vectoring(len, zz, elev);
            elev = fine_to_out(elev);
            if (elev < 0)
                elev = elev + TURN_OUT;
            pitch = TURN_OUT - elev;
            if (pitch > TURN_OUT)
                pitch = pitch - TURN_OUT;
            if (pitch < 0)
                pitch = pitch + TURN_OUT;
        end
        r.yaw_angle   = yaw[15:0];
        r.pitch_angle = pitch[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int beat, int got, int want);
        if (err_count < 100)
            $display("ERROR beat %0d: %s got %0d expected %0d", beat, what, got, want);
        err_count++;
    endtask

    // driver: sender side, changes on the falling edge
    always @(negedge aclk) begin
        vtyp_pkg::in_beat_t nxt_data;
        logic               nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_data  = s_data;
            if (s_valid && in_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (vec_queue.size() > 0) begin
                    nxt_data  = vec_queue.pop_front();
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 8);
                end
            end
            s_valid <= nxt_valid;
            s_data  <= nxt_data;
        end
    end

    // receiver side: random stall bursts plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: samples both channels on the rising edge
    always @(posedge aclk) begin
        vtyp_pkg::out_beat_t want;
        if (!aresetn) begin
            in_taken    = 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken = s_valid && s_ready;
            if (s_valid && !s_ready)
                backpressure++;
            if (in_taken) begin
                angle_queue.push_back(predict_angles(s_data));
                in_count++;
                if (in_count >= total_vecs - QUIET_TAIL)
                    quiet = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (angle_queue.size() == 0) begin
                    report_mismatch("unexpected beat, yaw", out_count,
                                    m_data.yaw_angle, 0);
                end else begin
                    want = angle_queue.pop_front();
                    if (m_data.yaw_angle !== want.yaw_angle)
                        report_mismatch("yaw_angle", out_count,
                                        m_data.yaw_angle, want.yaw_angle);
                    if (m_data.pitch_angle !== want.pitch_angle)
                        report_mismatch("pitch_angle", out_count,
                                        m_data.pitch_angle, want.pitch_angle);
                end
                out_count++;
            end
            if (in_taken || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("Timeout: no beat moved for %0d cycles", WATCHDOG);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        vtyp_pkg::in_beat_t v;
        int                 pick;
        for (int i = 0; i < 23; i++) begin
            v.x_coord = DIRECTED[i][0];
            v.y_coord = DIRECTED[i][1];
            v.z_coord = DIRECTED[i][2];
            vec_queue.push_back(v);
        end
        for (int i = 0; i < RANDOM_VECS; i++) begin
            v.x_coord = 16'($urandom());
            v.y_coord = 16'($urandom());
            v.z_coord = 16'($urandom());
            pick = $urandom_range(0, 9);
            case (pick)
                5: begin
                    v.x_coord = 16'(int'($urandom_range(0, 6)) - 3);
                    v.y_coord = 16'(int'($urandom_range(0, 6)) - 3);
                    v.z_coord = 16'(int'($urandom_range(0, 6)) - 3);
                end
                6: begin
                    if ($urandom_range(0, 1) == 0)
                        v.x_coord = '0;
                    else
                        v.y_coord = '0;
                end
                7: begin
                    v.x_coord = '0;
                    v.y_coord = '0;
                end
                8: begin
                    v.x_coord = CORNER_VALS[$urandom_range(0, 4)];
                    v.y_coord = CORNER_VALS[$urandom_range(0, 4)];
                    v.z_coord = CORNER_VALS[$urandom_range(0, 4)];
                end
                9: begin
                    v.x_coord = 16'(int'($urandom_range(0, 16)) - 8);
                    v.y_coord = 16'(int'($urandom_range(0, 16)) - 8);
                end
                default: ;
            endcase
            vec_queue.push_back(v);
        end
        total_vecs = vec_queue.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (in_count < total_vecs || angle_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (angle_queue.size() != 0)
            report_mismatch("results missing", out_count, 0, angle_queue.size());

        $display("Converted %0d vectors (corners, axes, zero-length and random)",
                 in_count);
        $display("with %0d results checked; input stalled by the pipe on %0d cycles",
                 out_count, backpressure);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
